// ===== hw/rtl/nhr_pkg.sv =====
// ----------------------------------------------------------------------------
// nhr_pkg
// Shared types, codes and defaults for the next-hop resolver.
// ----------------------------------------------------------------------------
`default_nettype none

package nhr_pkg;

  localparam int ADDR_W           = 64;
  localparam int IDX_W            = 5;
  localparam int LINK_SLOTS_DEF   = 32;
  localparam int ROUTE_SLOTS_DEF  = 32;

  // Item operation codes; code 3 is unused and does nothing.
  typedef enum logic [1:0] {
    OP_LINK_WR  = 2'd0,
    OP_ROUTE_WR = 2'd1,
    OP_RESOLVE  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_DIRECT    = 2'd0,
    ST_DEDICATED = 2'd1,
    ST_DEFAULT   = 2'd2,
    ST_NONE      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LINK,
    S_ROUTE,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] sender;
    logic [ADDR_W-1:0] receiver;
  } link_ent_t;

  typedef struct packed {
    logic [ADDR_W-1:0] owner;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] hop;
    logic              is_default;
  } route_ent_t;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic link_wr;
    logic route_wr;
    logic link_rd;
    logic route_rd;
    logic addr_clr;
    logic addr_inc;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic link_last;
    logic route_last;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nhr_if.sv =====
// ----------------------------------------------------------------------------
// nhr_req_if / nhr_res_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface nhr_req_if import nhr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [IDX_W-1:0]  entry_index;
  logic              entry_valid;
  logic [ADDR_W-1:0] first_addr;
  logic [ADDR_W-1:0] second_addr;
  logic [ADDR_W-1:0] hop_addr;
  logic              route_is_default;
  logic [ADDR_W-1:0] dest_addr;

  modport source (
    output valid, opcode, entry_index, entry_valid, first_addr, second_addr,
           hop_addr, route_is_default, dest_addr,
    input  ready
  );
  modport sink (
    input  valid, opcode, entry_index, entry_valid, first_addr, second_addr,
           hop_addr, route_is_default, dest_addr,
    output ready
  );
endinterface

interface nhr_res_if import nhr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        route_status;
  logic [ADDR_W-1:0] next_hop;

  modport source (
    output valid, route_status, next_hop,
    input  ready
  );
  modport sink (
    input  valid, route_status, next_hop,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/next_hop_resolver_top.sv =====
// ----------------------------------------------------------------------------
// next_hop_resolver_top
// Next-hop lookup over a scheduled-link table and a route table.
// ----------------------------------------------------------------------------
// Each request item is a link write, a route write or a resolve. Writes
// complete in the cycle they are accepted and give no result; a write to a
// slot beyond the table is dropped, and entry_valid low retires the slot.
// A resolve walks the link table one slot per cycle through its memory read
// port, then the route table the same way, and returns one result item: a
// direct link to the destination wins, then the lowest dedicated route owned
// by this node, then the highest default route of this node, else no route
// with a zero hop. A resolve holds the input through the link scan, route
// scan, drain and finish states, as the scans run in turn on single read
// ports; a write item leaves the input ready. The result register lets a
// new item enter while the previous result waits to be taken; a resolve
// that finishes before that holds until the result register frees. Write
// cfg_wdata (this node's identifier) only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module next_hop_resolver_top import nhr_pkg::*; #(
  parameter int LINK_SLOTS  = LINK_SLOTS_DEF,
  parameter int ROUTE_SLOTS = ROUTE_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  nhr_req_if.sink                in_req,
  nhr_res_if.source              out_res,
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_wdata
);

  cmd_t    cmd;
  stat_t   stat;
  logic    in_ready;
  logic    out_valid;
  status_t out_status;
  logic [ADDR_W-1:0] out_hop;

  // Sequencer: owns the input handshake and every step of a resolve
  nhr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .opcode   (in_req.opcode),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Tables, compare stage and result register
  nhr_datapath #(
    .LINK_SLOTS  (LINK_SLOTS),
    .ROUTE_SLOTS (ROUTE_SLOTS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .entry_index      (in_req.entry_index),
    .entry_valid      (in_req.entry_valid),
    .first_addr       (in_req.first_addr),
    .second_addr      (in_req.second_addr),
    .hop_addr         (in_req.hop_addr),
    .route_is_default (in_req.route_is_default),
    .dest_addr        (in_req.dest_addr),
    .out_valid        (out_valid),
    .out_ready        (out_res.ready),
    .out_status       (out_status),
    .out_hop          (out_hop)
  );

  assign in_req.ready         = in_ready;
  assign out_res.valid        = out_valid;
  assign out_res.route_status = out_status;
  assign out_res.next_hop     = out_hop;

endmodule

`default_nettype wire

// ===== hw/rtl/nhr_datapath.sv =====
// ----------------------------------------------------------------------------
// nhr_datapath
// Link and route tables, scan address, match flags and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nhr_datapath import nhr_pkg::*; #(
  parameter int LINK_SLOTS  = LINK_SLOTS_DEF,
  parameter int ROUTE_SLOTS = ROUTE_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  output      stat_t             stat,
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_wdata,
  input  wire logic [IDX_W-1:0]  entry_index,
  input  wire logic              entry_valid,
  input  wire logic [ADDR_W-1:0] first_addr,
  input  wire logic [ADDR_W-1:0] second_addr,
  input  wire logic [ADDR_W-1:0] hop_addr,
  input  wire logic              route_is_default,
  input  wire logic [ADDR_W-1:0] dest_addr,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      status_t           out_status,
  output      logic [ADDR_W-1:0] out_hop
);

  localparam int LINK_AW  = (LINK_SLOTS > 1) ? $clog2(LINK_SLOTS) : 1;
  localparam int ROUTE_AW = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
  localparam int AW       = (LINK_AW > ROUTE_AW) ? LINK_AW : ROUTE_AW;

  link_ent_t  link_mem  [LINK_SLOTS];
  route_ent_t route_mem [ROUTE_SLOTS];

  logic [LINK_SLOTS-1:0]  link_act_r;
  logic [ROUTE_SLOTS-1:0] route_act_r;
  logic [ADDR_W-1:0]      my_id_r;
  logic [ADDR_W-1:0]      dest_r;
  logic [AW-1:0]          addr_r;

  link_ent_t              lk_ent_r;
  logic                   lk_act_r;
  logic                   lk_cmp_r;
  route_ent_t             rt_ent_r;
  logic                   rt_act_r;
  logic                   rt_cmp_r;

  logic                   link_hit_r;
  logic                   ded_hit_r;
  logic [ADDR_W-1:0]      ded_hop_r;
  logic                   def_seen_r;
  logic [ADDR_W-1:0]      def_hop_r;

  logic                   out_valid_r;
  status_t                out_status_r;
  logic [ADDR_W-1:0]      out_hop_r;

  logic                   link_in_range;
  logic                   route_in_range;
  logic [LINK_AW-1:0]     link_widx;
  logic [ROUTE_AW-1:0]    route_widx;
  logic                   link_match;
  logic                   route_mine;
  status_t                res_status;
  logic [ADDR_W-1:0]      res_hop;

  assign link_in_range  = int'(entry_index) < LINK_SLOTS;
  assign route_in_range = int'(entry_index) < ROUTE_SLOTS;
  assign link_widx      = LINK_AW'(entry_index);
  assign route_widx     = ROUTE_AW'(entry_index);

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_id_r <= '0;
    end else if (cfg_we) begin
      my_id_r <= cfg_wdata;
    end
  end

  // Table writes and registered scan reads
  always_ff @(posedge clk) begin
    if (cmd.link_wr && link_in_range) begin
      link_mem[link_widx] <= '{sender: first_addr, receiver: second_addr};
    end
    if (cmd.link_rd) begin
      lk_ent_r <= link_mem[addr_r[LINK_AW-1:0]];
      lk_act_r <= link_act_r[addr_r[LINK_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.route_wr && route_in_range) begin
      route_mem[route_widx] <= '{owner: first_addr, dest: second_addr,
                                 hop: hop_addr, is_default: route_is_default};
    end
    if (cmd.route_rd) begin
      rt_ent_r <= route_mem[addr_r[ROUTE_AW-1:0]];
      rt_act_r <= route_act_r[addr_r[ROUTE_AW-1:0]];
    end
  end

  // Slot active bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_act_r  <= '0;
      route_act_r <= '0;
    end else begin
      if (cmd.link_wr && link_in_range) begin
        link_act_r[link_widx] <= entry_valid;
      end
      if (cmd.route_wr && route_in_range) begin
        route_act_r[route_widx] <= entry_valid;
      end
    end
  end

  // Scan address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
    end else if (cmd.addr_clr) begin
      addr_r <= '0;
    end else if (cmd.addr_inc) begin
      addr_r <= addr_r + AW'(1);
    end
  end

  assign stat.link_last  = (addr_r == AW'(LINK_SLOTS - 1));
  assign stat.route_last = (addr_r == AW'(ROUTE_SLOTS - 1));

  // Compare stage works on the registered read data in the cycle after the read
  assign link_match = lk_act_r &&
                      (((lk_ent_r.sender == my_id_r) && (lk_ent_r.receiver == dest_r)) ||
                       ((lk_ent_r.sender == dest_r) && (lk_ent_r.receiver == my_id_r)));
  assign route_mine = rt_act_r && (rt_ent_r.owner == my_id_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_cmp_r   <= 1'b0;
      rt_cmp_r   <= 1'b0;
      link_hit_r <= 1'b0;
      ded_hit_r  <= 1'b0;
      def_seen_r <= 1'b0;
    end else begin
      lk_cmp_r <= cmd.link_rd;
      rt_cmp_r <= cmd.route_rd;
      if (cmd.start) begin
        link_hit_r <= 1'b0;
        ded_hit_r  <= 1'b0;
        def_seen_r <= 1'b0;
      end else begin
        if (lk_cmp_r && link_match) begin
          link_hit_r <= 1'b1;
        end
        if (rt_cmp_r && route_mine) begin
          if (rt_ent_r.is_default) begin
            def_seen_r <= 1'b1;
          end else if (!ded_hit_r && (rt_ent_r.dest == dest_r)) begin
            ded_hit_r <= 1'b1;
          end
        end
      end
    end
  end

  // Hop payloads: keep the first dedicated match and the last default
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dest_r <= dest_addr;
    end
    if (rt_cmp_r && route_mine) begin
      if (rt_ent_r.is_default) begin
        def_hop_r <= rt_ent_r.hop;
      end else if (!ded_hit_r && (rt_ent_r.dest == dest_r)) begin
        ded_hop_r <= rt_ent_r.hop;
      end
    end
  end

  always_comb begin
    if (link_hit_r) begin
      res_status = ST_DIRECT;
      res_hop    = dest_r;
    end else if (ded_hit_r) begin
      res_status = ST_DEDICATED;
      res_hop    = ded_hop_r;
    end else if (def_seen_r) begin
      res_status = ST_DEFAULT;
      res_hop    = def_hop_r;
    end else begin
      res_status = ST_NONE;
      res_hop    = '0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= res_status;
      out_hop_r    <= res_hop;
    end
  end

  assign stat.out_busy = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_hop       = out_hop_r;

endmodule

`default_nettype wire

// ===== hw/rtl/nhr_ctrl.sv =====
// ----------------------------------------------------------------------------
// nhr_ctrl
// Sequencer: accepts items, steps the table scans, loads the result.
// ----------------------------------------------------------------------------
`default_nettype none

module nhr_ctrl import nhr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [1:0] opcode,
  input  wire stat_t      stat,
  output      cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && (opcode == OP_RESOLVE)) begin
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        if (stat.link_last) begin
          state_nxt = S_ROUTE;
        end
      end
      S_ROUTE: begin
        if (stat.route_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        // ready is held high throughout idle, so valid alone marks the accept
        in_ready     = 1'b1;
        cmd.link_wr  = in_valid && (opcode == OP_LINK_WR);
        cmd.route_wr = in_valid && (opcode == OP_ROUTE_WR);
        cmd.start    = in_valid && (opcode == OP_RESOLVE);
        cmd.addr_clr = cmd.start;
      end
      S_LINK: begin
        cmd.link_rd  = 1'b1;
        cmd.addr_clr = stat.link_last;
        cmd.addr_inc = !stat.link_last;
      end
      S_ROUTE: begin
        cmd.route_rd = 1'b1;
        cmd.addr_inc = !stat.route_last;
      end
      S_DRAIN: begin
        cmd = '0;
      end
      S_FINISH: begin
        cmd.load_out = !stat.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/next_hop_resolver_top_test.sv =====
// ----------------------------------------------------------------------------
// next_hop_resolver_top_test
// Self-checking bench for the next-hop resolver. A queue of request items
// (link writes, route writes, resolves and unused codes) feeds a burst-paced
// driver, the result channel stalls on a pattern of its own, and every result
// item is checked against a behavioural copy of both tables and the node ID.
// ----------------------------------------------------------------------------
module next_hop_resolver_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nhr_pkg::*;

  // Code 3 is left out of op_t; name it here so it is never written bare.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Cycles to let pass once the block looks idle: enough for one full resolve
  // scan with some margin.
  localparam int SETTLE_CYCLES = LINK_SLOTS_DEF + ROUTE_SLOTS_DEF + 20;
  localparam int SETTLE_GUARD  = 400000;
  localparam int RAND_PHASES   = 6;
  localparam int PHASE_ITEMS   = 172;
  localparam int REPORT_LIMIT  = 40;

  typedef struct {
    logic [1:0]        opcode;
    logic [IDX_W-1:0]  idx;
    logic              enable;
    logic [ADDR_W-1:0] first_a;
    logic [ADDR_W-1:0] second_a;
    logic [ADDR_W-1:0] hop_a;
    logic              dflt;
    logic [ADDR_W-1:0] dst_a;
    bit                drain_first;  // hold this item until all results are in
  } req_item_t;

  typedef struct {
    status_t           status;
    logic [ADDR_W-1:0] hop;
  } hop_result_t;

  typedef enum {RX_OPEN, RX_SPARSE, RX_PERIODIC, RX_CHOKED} rx_mode_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [ADDR_W-1:0] cfg_wdata;

  nhr_req_if req_ch ();
  nhr_res_if res_ch ();

  next_hop_resolver_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Behavioural copy of the block's state
  logic [ADDR_W-1:0] node_id;
  logic [ADDR_W-1:0] link_snd  [LINK_SLOTS_DEF];
  logic [ADDR_W-1:0] link_rcv  [LINK_SLOTS_DEF];
  logic              link_on   [LINK_SLOTS_DEF];
  logic [ADDR_W-1:0] route_own [ROUTE_SLOTS_DEF];
  logic [ADDR_W-1:0] route_dst [ROUTE_SLOTS_DEF];
  logic [ADDR_W-1:0] route_nh  [ROUTE_SLOTS_DEF];
  logic              route_dflt[ROUTE_SLOTS_DEF];
  logic              route_on  [ROUTE_SLOTS_DEF];

  req_item_t   pending_reqs[$];
  hop_result_t awaited_hops[$];

  // Driver / receiver pacing
  bit       in_taken;
  int       burst_left;
  int       gap_left;
  rx_mode_t rx_mode;
  int       rx_left;
  int       rx_period;

  // Bookkeeping
  int err_cnt;
  int n_accepted;
  int n_resolves;
  int n_ignored;
  int n_checked;
  int n_status[4];
  int n_ids;
  logic [ADDR_W-1:0] addr_pool[6];

  // ---------------------------------------------------------------------------
  // Next-hop prediction: a direct link in either direction wins, then the
  // lowest dedicated route of this node, then the highest default route.
  // ---------------------------------------------------------------------------
  function automatic hop_result_t resolve_next_hop(logic [ADDR_W-1:0] dst);
    hop_result_t       r;
    logic              have_dflt;
    logic [ADDR_W-1:0] dflt_hop;
    r.status  = ST_NONE;
    r.hop     = '0;
    have_dflt = 1'b0;
    dflt_hop  = '0;
    for (int s = 0; s < LINK_SLOTS_DEF; s++) begin
      if (link_on[s] && ((link_snd[s] == node_id && link_rcv[s] == dst) ||
                         (link_snd[s] == dst && link_rcv[s] == node_id))) begin
        r.status = ST_DIRECT;
        r.hop    = dst;
        return r;
      end
    end
    for (int s = 0; s < ROUTE_SLOTS_DEF; s++) begin
      if (route_on[s] && route_own[s] == node_id) begin
        // a default route's destination is never compared
        if (route_dflt[s]) begin
          have_dflt = 1'b1;
          dflt_hop  = route_nh[s];
        end else if (route_dst[s] == dst) begin
          r.status = ST_DEDICATED;
          r.hop    = route_nh[s];
          return r;
        end
      end
    end
    if (have_dflt) begin
      r.status = ST_DEFAULT;
      r.hop    = dflt_hop;
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Bias addresses towards this node and a small pool so that links and
  // routes actually match; the rest are fully random.
  function automatic logic [ADDR_W-1:0] pick_addr(logic [ADDR_W-1:0] id);
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return id;
    if (r < 85) return addr_pool[$urandom_range(0, 5)];
    return rand64();
  endfunction

  function automatic void push_item(logic [1:0] op, int idx, logic enable,
                                    logic [ADDR_W-1:0] first_a,
                                    logic [ADDR_W-1:0] second_a,
                                    logic [ADDR_W-1:0] hop_a, logic dflt,
                                    logic [ADDR_W-1:0] dst_a, bit drain_first);
    req_item_t it;
    it.opcode      = op;
    it.idx         = idx[IDX_W-1:0];
    it.enable      = enable;
    it.first_a     = first_a;
    it.second_a    = second_a;
    it.hop_a       = hop_a;
    it.dflt        = dflt;
    it.dst_a       = dst_a;
    it.drain_first = drain_first;
    pending_reqs.push_back(it);
  endfunction

  // Wait until every queued item has gone in and every result has come back,
  // then wait SETTLE_CYCLES more for the block to go quiet.
  task automatic settle();
    int guard;
    guard = 0;
    while ((pending_reqs.size() != 0 || req_ch.valid || awaited_hops.size() != 0)
           && guard < SETTLE_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_id(logic [ADDR_W-1:0] v);
    @(negedge clk);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    n_ids++;
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Hard stop in case the block hangs
  // ---------------------------------------------------------------------------
  initial begin
    #4ms;
    $display("Timeout: %0d results still awaited, %0d items not yet sent",
             awaited_hops.size(), pending_reqs.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: present queued items at the falling edge, in bursts separated by
  // random gaps. Hold the current item until the rising edge takes it.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : req_drive
    logic      nv;
    req_item_t it;
    if (!(req_ch.valid && !in_taken)) begin
      in_taken = 1'b0;
      nv       = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].drain_first && awaited_hops.size() != 0)) begin
        it = pending_reqs.pop_front();
        req_ch.opcode           <= it.opcode;
        req_ch.entry_index      <= it.idx;
        req_ch.entry_valid      <= it.enable;
        req_ch.first_addr       <= it.first_a;
        req_ch.second_addr      <= it.second_a;
        req_ch.hop_addr         <= it.hop_a;
        req_ch.route_is_default <= it.dflt;
        req_ch.dest_addr        <= it.dst_a;
        nv = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // mostly short bursts with gaps; now and then a long gap-free run
          if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(30, 80);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      req_ch.valid <= nv;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a mode, drawn at random and held for a random run,
  // that ranges from always open to almost shut.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : res_accept
    logic r;
    if (rx_left == 0) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 3));
      rx_left   = $urandom_range(40, 300);
      rx_period = $urandom_range(3, 17);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:     r = 1'b1;
      RX_SPARSE:   r = ($urandom_range(0, 3) != 0);
      RX_PERIODIC: r = ((rx_left % rx_period) < (rx_period / 2));
      default:     r = ($urandom_range(0, 15) == 0);
    endcase
    res_ch.ready <= r;
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge apply configuration and accepted items to the
  // model, then check any result item taken against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : observe
    hop_result_t exp_r;
    int          ix;
    if (rst_n) begin
      if (cfg_we) node_id = cfg_wdata;

      if (req_ch.valid && req_ch.ready) begin
        in_taken = 1'b1;
        n_accepted++;
        ix = int'(req_ch.entry_index);
        case (req_ch.opcode)
          OP_LINK_WR: begin
            if (ix < LINK_SLOTS_DEF) begin
              link_snd[ix] = req_ch.first_addr;
              link_rcv[ix] = req_ch.second_addr;
              link_on[ix]  = req_ch.entry_valid;
            end
          end
          OP_ROUTE_WR: begin
            if (ix < ROUTE_SLOTS_DEF) begin
              route_own[ix]  = req_ch.first_addr;
              route_dst[ix]  = req_ch.second_addr;
              route_nh[ix]   = req_ch.hop_addr;
              route_dflt[ix] = req_ch.route_is_default;
              route_on[ix]   = req_ch.entry_valid;
            end
          end
          OP_RESOLVE: begin
            n_resolves++;
            awaited_hops.push_back(resolve_next_hop(req_ch.dest_addr));
          end
          default: n_ignored++;
        endcase
      end

      if (res_ch.valid && res_ch.ready) begin
        if (awaited_hops.size() == 0) begin
          err_cnt++;
          if (err_cnt <= REPORT_LIMIT)
            $display("%0t: unexpected result item, status %0d hop %h", $time,
                     res_ch.route_status, res_ch.next_hop);
        end else begin
          exp_r = awaited_hops.pop_front();
          n_checked++;
          n_status[exp_r.status]++;
          if (res_ch.route_status !== exp_r.status) begin
            err_cnt++;
            if (err_cnt <= REPORT_LIMIT)
              $display("%0t: route_status expected %0d (%s) actual %0d", $time,
                       exp_r.status, exp_r.status.name(), res_ch.route_status);
          end
          if (res_ch.next_hop !== exp_r.hop) begin
            err_cnt++;
            if (err_cnt <= REPORT_LIMIT)
              $display("%0t: next_hop expected %h actual %h", $time,
                       exp_r.hop, res_ch.next_hop);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [ADDR_W-1:0] my_a;
    logic [ADDR_W-1:0] d1;
    logic [ADDR_W-1:0] d2;
    logic [ADDR_W-1:0] stranger;
    logic [ADDR_W-1:0] phase_ids[RAND_PHASES];
    logic [ADDR_W-1:0] id;
    logic [ADDR_W-1:0] s_a;
    logic [ADDR_W-1:0] r_a;
    int                made;
    int                n_wr;
    int                n_rd;

    // Drive every input to a known value from time zero
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_wdata               = '0;
    req_ch.valid            = 1'b0;
    req_ch.opcode           = OP_LINK_WR;
    req_ch.entry_index      = '0;
    req_ch.entry_valid      = 1'b0;
    req_ch.first_addr       = '0;
    req_ch.second_addr      = '0;
    req_ch.hop_addr         = '0;
    req_ch.route_is_default = 1'b0;
    req_ch.dest_addr        = '0;
    res_ch.ready            = 1'b0;
    in_taken                = 1'b0;
    burst_left              = 4;
    gap_left                = 0;
    rx_mode                 = RX_OPEN;
    rx_left                 = 0;
    rx_period               = 4;
    node_id                 = '0;
    foreach (link_on[i]) begin
      link_snd[i] = '0;
      link_rcv[i] = '0;
      link_on[i]  = 1'b0;
    end
    foreach (route_on[i]) begin
      route_own[i]  = '0;
      route_dst[i]  = '0;
      route_nh[i]   = '0;
      route_dflt[i] = 1'b0;
      route_on[i]   = 1'b0;
    end

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // --- Directed part ------------------------------------------------------
    my_a     = 64'h0123_4567_89ab_cdef;
    d1       = 64'hfeed_0000_0000_0001;
    d2       = 64'h8000_0000_0000_0000;
    stranger = 64'h5555_aaaa_5555_aaaa;

    // Resolve against empty tables with the reset ID; unused code does nothing
    push_item(OP_RESOLVE, 0, 1'b0, '0, '0, '0, 1'b0, d1, 1'b0);
    push_item(OP_UNUSED, 31, 1'b1, '1, '1, '1, 1'b1, '1, 1'b0);
    settle();
    write_node_id(my_a);

    // Default route whose stored destination equals d1: must not match as
    // dedicated. A second default lower down loses to the highest slot.
    push_item(OP_ROUTE_WR, 31, 1'b1, my_a, d1, 64'hdef0_0000_0000_0031, 1'b1, '0, 1'b0);
    push_item(OP_RESOLVE, 0, 1'b0, '0, '0, '0, 1'b0, d1, 1'b0);
    push_item(OP_ROUTE_WR, 0, 1'b1, my_a, d2, 64'hdef0_0000_0000_0000, 1'b1, '0, 1'b0);
    push_item(OP_RESOLVE, 0, 1'b0, '0, '0, '0, 1'b0, d2, 1'b0);
    // Two dedicated routes to d1: the lower slot wins
    push_item(OP_ROUTE_WR, 5, 1'b1, my_a, d1, 64'h0000_0000_0000_0005, 1'b0, '0, 1'b0);
    push_item(OP_ROUTE_WR, 3, 1'b1, my_a, d1, 64'h0000_0000_0000_0003, 1'b0, '0, 1'b0);
    push_item(OP_RESOLVE, 0, 1'b0, '0, '0, '0, 1'b0, d1, 1'b0);
    // A route owned by another node is ignored even in a lower slot
    push_item(OP_ROUTE_WR, 1, 1'b1, stranger, d1, '1, 1'b0, '0, 1'b0);
    push_item(OP_RESOLVE, 0, 1'b0, '0, '0, '0, 1'b0, d1, 1'b1);
    // Direct link this node -> d1 beats the routes
    push_item(OP_LINK_WR, 0, 1'b1, my_a, d1, '0, 1'b0, '0, 1'b0);
    push_item(OP_RESOLVE, 0, 1'b0, '0, '0, '0, 1'b0, d1, 1'b0);
    // Clear it; the reverse direction in the top slot also counts as direct
    push_item(OP_LINK_WR, 0, 1'b0, my_a, d1, '0, 1'b0, '0, 1'b0);
    push_item(OP_LINK_WR, 31, 1'b1, d1, my_a, '0, 1'b0, '0, 1'b0);
    push_item(OP_RESOLVE, 0, 1'b0, '0, '0, '0, 1'b0, d1, 1'b0);
    // Retire the link and the winning route: next dedicated slot takes over
    push_item(OP_LINK_WR, 31, 1'b0, d1, my_a, '0, 1'b0, '0, 1'b0);
    push_item(OP_ROUTE_WR, 3, 1'b0, my_a, d1, '0, 1'b0, '0, 1'b0);
    push_item(OP_RESOLVE, 0, 1'b0, '0, '0, '0, 1'b0, d1, 1'b0);
    // Address extremes on a link that does not touch this node
    push_item(OP_LINK_WR, 7, 1'b1, '1, '0, '1, 1'b1, '1, 1'b0);
    push_item(OP_RESOLVE, 0, 1'b0, '0, '0, '0, 1'b0, '1, 1'b0);
    push_item(OP_RESOLVE, 0, 1'b0, '0, '0, '0, 1'b0, '0, 1'b0);
    // Drop the top default: the lower default route is now the last one
    push_item(OP_ROUTE_WR, 31, 1'b0, my_a, '0, '1, 1'b1, '0, 1'b0);
    push_item(OP_RESOLVE, 0, 1'b0, '0, '0, '0, 1'b0, stranger, 1'b0);
    settle();

    // --- Random part --------------------------------------------------------
    // Each phase runs under its own node ID, extremes included.
    phase_ids[0] = '1;
    phase_ids[1] = '0;
    phase_ids[2] = rand64();
    phase_ids[3] = 64'h8000_0000_0000_0000;
    phase_ids[4] = rand64();
    phase_ids[5] = 64'h0000_0000_0000_0001;

    for (int p = 0; p < RAND_PHASES; p++) begin
      id           = phase_ids[p];
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int k = 2; k < 6; k++) addr_pool[k] = rand64();
      write_node_id(id);

      made = 0;
      while (made < PHASE_ITEMS) begin
        // A well-formed group: a few table writes, then resolves into them
        n_wr = $urandom_range(1, 4);
        n_rd = $urandom_range(1, 3);
        for (int w = 0; w < n_wr; w++) begin
          if ($urandom_range(0, 99) < 40) begin
            if ($urandom_range(0, 3) != 0) begin
              s_a = id;
              r_a = pick_addr(id);
              if ($urandom_range(0, 1) == 0) begin
                s_a = r_a;
                r_a = id;
              end
            end else begin
              s_a = pick_addr(id);
              r_a = pick_addr(id);
            end
            push_item(OP_LINK_WR, $urandom_range(0, 31), ($urandom_range(0, 9) != 0),
                      s_a, r_a, rand64(), 1'($urandom_range(0, 1)), rand64(),
                      (made == 0));
          end else begin
            push_item(OP_ROUTE_WR, $urandom_range(0, 31), ($urandom_range(0, 6) != 0),
                      ($urandom_range(0, 9) < 7) ? id : pick_addr(id),
                      pick_addr(id),
                      ($urandom_range(0, 1) == 0) ? rand64() : pick_addr(id),
                      ($urandom_range(0, 3) == 0), rand64(), (made == 0));
          end
          made++;
        end
        for (int q = 0; q < n_rd; q++) begin
          push_item(OP_RESOLVE, $urandom_range(0, 31), 1'($urandom_range(0, 1)),
                    rand64(), rand64(), rand64(), 1'($urandom_range(0, 1)),
                    pick_addr(id), ($urandom_range(0, 79) == 0));
          made++;
        end
        // Noise: unused codes and fully random items
        if ($urandom_range(0, 7) == 0) begin
          push_item(OP_UNUSED, $urandom_range(0, 31), 1'($urandom_range(0, 1)),
                    rand64(), rand64(), rand64(), 1'($urandom_range(0, 1)),
                    rand64(), 1'b0);
        end
        if ($urandom_range(0, 9) == 0) begin
          push_item(OP_RESOLVE, $urandom_range(0, 31), 1'($urandom_range(0, 1)),
                    rand64(), rand64(), rand64(), 1'($urandom_range(0, 1)),
                    rand64(), 1'b0);
          made++;
        end
      end
      settle();
    end

    // --- End of run ---------------------------------------------------------
    if (awaited_hops.size() != 0) begin
      err_cnt += awaited_hops.size();
      $display("%0t: %0d expected results never arrived", $time, awaited_hops.size());
    end
    $display("Run covered %0d items (%0d resolves, %0d unused codes) under %0d node IDs.",
             n_accepted, n_resolves, n_ignored, n_ids);
    $display("Results checked %0d: %0d direct, %0d dedicated, %0d default, %0d unrouted.",
             n_checked, n_status[ST_DIRECT], n_status[ST_DEDICATED],
             n_status[ST_DEFAULT], n_status[ST_NONE]);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
